FILE: design/itoa_fmt_pkg.sv
// ----------------------------------------------------------------------------
// itoa_fmt_pkg
// Shared types, format codes and character tables for the integer to ASCII
// formatter.
// ----------------------------------------------------------------------------
package itoa_fmt_pkg;

  // format kinds
  localparam logic [2:0] KIND_SDEC = 3'd0;
  localparam logic [2:0] KIND_UDEC = 3'd1;
  localparam logic [2:0] KIND_HEXL = 3'd2;
  localparam logic [2:0] KIND_HEXU = 3'd3;
  localparam logic [2:0] KIND_PTR  = 3'd4;

  // digit store geometry: sixteen nibbles, most significant digit on top
  localparam int unsigned STORE_BITS = 64;
  localparam int unsigned BIN_BITS   = 32;
  localparam int unsigned BCD_DIGITS = 10;
  localparam int unsigned BCD_BITS   = BCD_DIGITS * 4;
  localparam int unsigned REM_W      = 5;

  localparam logic [REM_W-1:0] REM_DEC   = 5'd10;
  localparam logic [REM_W-1:0] REM_HEX32 = 5'd8;
  localparam logic [REM_W-1:0] REM_HEX64 = 5'd16;
  localparam logic [REM_W-1:0] REM_ONE   = 5'd1;

  localparam logic [4:0] CONV_LAST = 5'd31;
  localparam logic [2:0] NIL_LAST  = 3'd4;

  // fixed characters
  localparam logic [7:0] CHR_MINUS = 8'h2d;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_X     = 8'h78;

  // character source for the current beat
  typedef enum logic [2:0] {
    SEL_MINUS,
    SEL_ZERO,
    SEL_X,
    SEL_NIL,
    SEL_DIGIT
  } char_sel_e;

  // controller to datapath
  typedef struct packed {
    logic      load;
    logic      conv_step;
    logic      shift;
    logic      emit;
    char_sel_e sel;
    logic [2:0] nil_idx;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic neg;
    logic ptr_zero;
    logic conv_last;
    logic top_zero;
    logic rem_one;
  } dp_status_t;

  // digit to ASCII, either case for hex letters
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = 8'h30 + {4'd0, d};
    end else if (upper) begin
      c = 8'h41 + {4'd0, d - 4'd10};
    end else begin
      c = 8'h61 + {4'd0, d - 4'd10};
    end
    return c;
  endfunction

  // the "(nil)" text
  function automatic logic [7:0] nil_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h28;
      3'd1:    c = 8'h6e;
      3'd2:    c = 8'h69;
      3'd3:    c = 8'h6c;
      default: c = 8'h29;
    endcase
    return c;
  endfunction

endpackage

FILE: design/integer_to_ascii_formatter_top.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top
// Formats one integer per input beat as ASCII text, one character per
// output beat, most significant digit first.
// ----------------------------------------------------------------------------
// Usage:
//  - input channel (in_valid_i / in_stall_o) carries kind_i and value_i;
//    kinds 5 to 7 are taken and dropped without any output
//  - output channel (out_valid_o / out_stall_i) carries character_o,
//    last_o on the final character, and total_count_o, the saturating
//    number of characters sent since reset including this one
//  - one item is worked on at a time; in_stall_o stays high until the
//    last character of the current item has been taken
//  - decimal kinds run the shift-and-add-3 converter, then drop leading
//    zero digits before the digits are sent
//  - hex and pointer kinds skip the converter; hex goes straight to the
//    leading zero drop, pointer sends 0x first, or (nil) for a zero value
//  - one character goes out per cycle when the receiver does not stall
//  - a receiver stall holds the current character and freezes the block
//  - reset clears the state machine and the character count
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_top import itoa_fmt_pkg::*; #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [63:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  character_o,
  output logic        last_o,
  output logic [31:0] total_count_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencing and handshakes
  itoa_fmt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .last_o      (last_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // digit store, converter and counter
  itoa_fmt_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .kind_i        (kind_i),
    .value_i       (value_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .character_o   (character_o),
    .total_count_o (total_count_o)
  );

endmodule

FILE: design/itoa_fmt_dp.sv
// ----------------------------------------------------------------------------
// itoa_fmt_dp
// Datapath: digit store, shift-and-add-3 binary to BCD converter, remaining
// digit counter, character select and the saturating beat counter.
// ----------------------------------------------------------------------------
module itoa_fmt_dp import itoa_fmt_pkg::*; #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [2:0]  kind_i,
  input  logic [63:0] value_i,
  input  dp_cmd_t     cmd_i,
  output dp_status_t  status_o,
  output logic [7:0]  character_o,
  output logic [31:0] total_count_o
);

  logic [STORE_BITS-1:0] store_q, store_d;
  logic [BIN_BITS-1:0]   bin_q, bin_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [4:0]            iter_q, iter_d;
  logic                  upper_q, upper_d;
  logic [COUNT_BITS-1:0] count_q, count_d, count_next;
  logic [BCD_BITS-1:0]   bcd_corr;
  logic [31:0]           low;

  assign low = value_i[31:0];

  // add-3 correction on every BCD digit before the shift
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      bcd_corr[4*i +: 4] = (store_q[STORE_BITS-BCD_BITS+4*i +: 4] >= 4'd5)
                         ? store_q[STORE_BITS-BCD_BITS+4*i +: 4] + 4'd3
                         : store_q[STORE_BITS-BCD_BITS+4*i +: 4];
    end
  end

  // store, magnitude, digit count and conversion step counter
  always_comb begin
    store_d = store_q;
    bin_d   = bin_q;
    rem_d   = rem_q;
    iter_d  = iter_q;
    upper_d = upper_q;
    if (cmd_i.load) begin
      iter_d  = '0;
      upper_d = (kind_i == KIND_HEXU);
      case (kind_i) inside
        KIND_SDEC, KIND_UDEC: begin
          bin_d   = (kind_i == KIND_SDEC && low[31]) ? (~low + 32'd1) : low;
          store_d = '0;
          rem_d   = REM_DEC;
        end
        KIND_HEXL, KIND_HEXU: begin
          store_d = {low, 32'd0};
          rem_d   = REM_HEX32;
        end
        KIND_PTR: begin
          store_d = value_i;
          rem_d   = REM_HEX64;
        end
        default: ;
      endcase
    end else if (cmd_i.conv_step) begin
      store_d[STORE_BITS-1 -: BCD_BITS] = {bcd_corr[BCD_BITS-2:0], bin_q[BIN_BITS-1]};
      bin_d  = {bin_q[BIN_BITS-2:0], 1'b0};
      iter_d = iter_q + 5'd1;
    end else if (cmd_i.shift) begin
      store_d = {store_q[STORE_BITS-5:0], 4'd0};
      rem_d   = rem_q - REM_ONE;
    end
  end

  // saturating beat count
  assign count_next = (&count_q) ? count_q : count_q + 1'b1;
  assign count_d    = cmd_i.emit ? count_next : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= REM_ONE;
      iter_q  <= '0;
      count_q <= '0;
    end else begin
      rem_q   <= rem_d;
      iter_q  <= iter_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    store_q <= store_d;
    bin_q   <= bin_d;
    upper_q <= upper_d;
  end

  // status back to the controller
  assign status_o.neg       = (kind_i == KIND_SDEC) && low[31];
  assign status_o.ptr_zero  = (value_i == 64'd0);
  assign status_o.conv_last = (iter_q == CONV_LAST);
  assign status_o.top_zero  = (store_q[STORE_BITS-1 -: 4] == 4'd0);
  assign status_o.rem_one   = (rem_q == REM_ONE);

  // character of the current beat
  always_comb begin
    case (cmd_i.sel)
      SEL_MINUS: character_o = CHR_MINUS;
      SEL_ZERO:  character_o = CHR_ZERO;
      SEL_X:     character_o = CHR_X;
      SEL_NIL:   character_o = nil_char(cmd_i.nil_idx);
      default:   character_o = digit_char(store_q[STORE_BITS-1 -: 4], upper_q);
    endcase
  end

  assign total_count_o = 32'(count_next);

  // digit count stays within the store
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q != '0 && rem_q <= REM_HEX64)
    else $error("remaining digit count out of range");

  // count only moves on a beat, and never backwards
  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.emit |=> count_q == $past(count_q))
    else $error("beat count changed without a beat");

  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> count_q >= $past(count_q))
    else $error("beat count went backwards");

endmodule

FILE: design/itoa_fmt_ctrl.sv
// ----------------------------------------------------------------------------
// itoa_fmt_ctrl
// Controller: sequences sign, prefix, (nil) text, conversion, leading zero skip and
// digit beats, and drives the handshakes.
// ----------------------------------------------------------------------------
module itoa_fmt_ctrl import itoa_fmt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] kind_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       last_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MINUS,
    S_CONV,
    S_PFX0,
    S_PFX1,
    S_NIL,
    S_SKIP,
    S_DIGIT
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] nil_idx_q, nil_idx_d;
  logic       beat;

  assign beat = out_valid_o && !out_stall_i;

  // next state and datapath commands
  always_comb begin
    state_d         = state_q;
    nil_idx_d       = nil_idx_q;
    in_stall_o      = 1'b1;
    out_valid_o     = 1'b0;
    last_o          = 1'b0;
    cmd_o           = '0;
    cmd_o.sel       = SEL_DIGIT;
    cmd_o.nil_idx   = nil_idx_q;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          nil_idx_d  = '0;
          case (kind_i) inside
            KIND_SDEC:            state_d = status_i.neg ? S_MINUS : S_CONV;
            KIND_UDEC:            state_d = S_CONV;
            KIND_HEXL, KIND_HEXU: state_d = S_SKIP;
            KIND_PTR:             state_d = status_i.ptr_zero ? S_NIL : S_PFX0;
            default:              state_d = S_IDLE;
          endcase
        end
      end
      S_MINUS: begin
        out_valid_o = 1'b1;
        cmd_o.sel   = SEL_MINUS;
        if (!out_stall_i) state_d = S_CONV;
      end
      S_CONV: begin
        cmd_o.conv_step = 1'b1;
        if (status_i.conv_last) state_d = S_SKIP;
      end
      S_PFX0: begin
        out_valid_o = 1'b1;
        cmd_o.sel   = SEL_ZERO;
        if (!out_stall_i) state_d = S_PFX1;
      end
      S_PFX1: begin
        out_valid_o = 1'b1;
        cmd_o.sel   = SEL_X;
        if (!out_stall_i) state_d = S_SKIP;
      end
      S_NIL: begin
        out_valid_o = 1'b1;
        cmd_o.sel   = SEL_NIL;
        last_o      = (nil_idx_q == NIL_LAST);
        if (!out_stall_i) begin
          nil_idx_d = nil_idx_q + 3'd1;
          if (nil_idx_q == NIL_LAST) state_d = S_IDLE;
        end
      end
      S_SKIP: begin
        // drop leading zeros, keep at least one digit
        if (status_i.top_zero && !status_i.rem_one) begin
          cmd_o.shift = 1'b1;
        end else begin
          state_d = S_DIGIT;
        end
      end
      S_DIGIT: begin
        out_valid_o = 1'b1;
        last_o      = status_i.rem_one;
        if (!out_stall_i) begin
          if (status_i.rem_one) state_d = S_IDLE;
          else cmd_o.shift = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
    cmd_o.emit = beat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      nil_idx_q <= '0;
    end else begin
      state_q   <= state_d;
      nil_idx_q <= nil_idx_d;
    end
  end

  // after the final beat the block is free for the next item
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat && last_o |=> !out_valid_o && !in_stall_o)
    else $error("block busy after last beat");

  // no item taken while beats are pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("input accepted while output pending");

  // conversion is never cut short by an input item
  a_conv_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.conv_step |-> in_stall_o && !cmd_o.load)
    else $error("load during conversion");

endmodule
